// ===== design/fifc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO replacement cache package
// Sizes, memory request types and shared constants of the cache unit.
// ----------------------------------------------------------------------------
package fifc_pkg;

  localparam int KEY_W     = 10;
  localparam int KEY_SPACE = 1 << KEY_W;
  localparam int BIT_W     = 4;
  localparam int ROW_BITS  = 1 << BIT_W;
  localparam int ROW_W     = KEY_W - BIT_W;
  localparam int ROWS      = 1 << ROW_W;
  localparam int SLOT_W    = 7;
  localparam int MAX_SLOTS = 1 << SLOT_W;
  localparam int CAP_W     = 8;
  localparam int MISS_W    = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic                en;
    logic                we;
    logic [ROW_W-1:0]    addr;
    logic [ROW_BITS-1:0] wdata;
  } fifc_map_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wdata;
  } fifc_ring_req_t;

endpackage
`default_nettype wire

// ===== design/fifo_replacement_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO replacement cache unit
// Key lookup against a presence bitmap with oldest-first eviction and a
// saturating miss counter.
// ----------------------------------------------------------------------------
// After reset the unit clears all 64 rows of its presence bitmap and accepts no
// item until that pass is done; configuration writes are taken at all times.
// Items are handled one at a time, and the single-port bitmap memory sets the
// pace: a hit reads the key's row, a free-slot miss reads and writes it, a
// miss that evicts a key of the same row reads it again before one write, and
// one that evicts from another row clears the old key before the new key is set. A
// finished result waits in the output register while the next item is accepted.
module fifo_replacement_cache_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [fifc_pkg::CAP_W-1:0]       cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: key[9:0], zero fill.
  input  wire  [fifc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // Fields from bit 0: hit, evicted_valid, evicted_key[9:0], miss_total[31:0], zero fill.
  output logic [fifc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import fifc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_SET   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [ROW_W-1:0]    clr_row_q, clr_row_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [CAP_W-1:0]    occ_q, occ_d;
  logic [MISS_W-1:0]   miss_q, miss_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [KEY_W-1:0]    old_q, old_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  fifc_map_req_t       map_req;
  fifc_ring_req_t      ring_req;
  logic [ROW_BITS-1:0] map_rdata;
  logic [KEY_W-1:0]    ring_rdata;

  logic                in_accept;
  logic                out_free;
  logic                full;
  logic                key_hit;
  logic [ROW_BITS-1:0] key_mask;
  logic [ROW_BITS-1:0] old_mask;
  logic [CAP_W:0]      tail_sum;
  logic [SLOT_W-1:0]   tail_pos;
  logic [SLOT_W-1:0]   head_next;
  logic [MISS_W-1:0]   miss_inc;
  logic [CAP_W-1:0]    cfg_cap;

  fifc_bitmap_ram u_map (
    .clk_i   (clk_i),
    .req_i   (map_req),
    .rdata_o (map_rdata)
  );

  fifc_ring_ram u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign full     = (occ_q >= cap_q);
  assign key_mask = ROW_BITS'(1) << key_q[BIT_W-1:0];
  assign old_mask = ROW_BITS'(1) << old_q[BIT_W-1:0];
  assign key_hit  = |(map_rdata & key_mask);
  assign tail_sum = {2'b00, head_q} + {1'b0, occ_q};
  assign tail_pos = (tail_sum >= {1'b0, cap_q}) ? SLOT_W'(tail_sum - {1'b0, cap_q})
                                                : tail_sum[SLOT_W-1:0];
  assign head_next = ({1'b0, head_q} + CAP_W'(1) >= cap_q) ? '0 : head_q + SLOT_W'(1);
  assign miss_inc  = (miss_q == '1) ? miss_q : miss_q + MISS_W'(1);

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_cap = CAP_W'(1);
    end else if (cfg_data_i > CAP_W'(MAX_SLOTS)) begin
      cfg_cap = CAP_W'(MAX_SLOTS);
    end else begin
      cfg_cap = cfg_data_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_row_d   = clr_row_q;
    cap_d       = cap_q;
    head_d      = head_q;
    occ_d       = occ_q;
    miss_d      = miss_q;
    key_d       = key_q;
    old_d       = old_q;
    row_d       = row_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    map_req     = '0;
    ring_req    = '0;

    if (cfg_valid_i && (miss_q == '0)) begin
      cap_d = cfg_cap;
    end

    unique case (state_q)
      ST_CLEAR: begin
        map_req.en   = 1'b1;
        map_req.we   = 1'b1;
        map_req.addr = clr_row_q;
        clr_row_d    = clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          key_d            = s_axis_tdata[KEY_W-1:0];
          map_req.en       = 1'b1;
          map_req.addr     = s_axis_tdata[KEY_W-1:BIT_W];
          ring_req.rd_en   = 1'b1;
          ring_req.rd_addr = head_q;
          state_d          = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (key_hit) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = {{(OUT_DATA_W - MISS_W - KEY_W - 2){1'b0}}, miss_q,
                           {KEY_W{1'b0}}, 1'b0, 1'b1};
            state_d     = ST_IDLE;
          end
        end else if (!full) begin
          if (out_free) begin
            map_req.en       = 1'b1;
            map_req.we       = 1'b1;
            map_req.addr     = key_q[KEY_W-1:BIT_W];
            map_req.wdata    = map_rdata | key_mask;
            ring_req.we      = 1'b1;
            ring_req.wr_addr = tail_pos;
            ring_req.wdata   = key_q;
            occ_d            = occ_q + CAP_W'(1);
            miss_d           = miss_inc;
            out_valid_d      = 1'b1;
            out_data_d       = {{(OUT_DATA_W - MISS_W - KEY_W - 2){1'b0}}, miss_inc,
                                {KEY_W{1'b0}}, 1'b0, 1'b0};
            state_d          = ST_IDLE;
          end
        end else begin
          row_d        = map_rdata;
          old_d        = ring_rdata;
          map_req.en   = 1'b1;
          map_req.addr = ring_rdata[KEY_W-1:BIT_W];
          state_d      = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (old_q[KEY_W-1:BIT_W] == key_q[KEY_W-1:BIT_W]) begin
          if (out_free) begin
            map_req.en       = 1'b1;
            map_req.we       = 1'b1;
            map_req.addr     = key_q[KEY_W-1:BIT_W];
            map_req.wdata    = (map_rdata & ~old_mask) | key_mask;
            ring_req.we      = 1'b1;
            ring_req.wr_addr = head_q;
            ring_req.wdata   = key_q;
            head_d           = head_next;
            miss_d           = miss_inc;
            out_valid_d      = 1'b1;
            out_data_d       = {{(OUT_DATA_W - MISS_W - KEY_W - 2){1'b0}}, miss_inc,
                                old_q, 1'b1, 1'b0};
            state_d          = ST_IDLE;
          end
        end else begin
          map_req.en    = 1'b1;
          map_req.we    = 1'b1;
          map_req.addr  = old_q[KEY_W-1:BIT_W];
          map_req.wdata = map_rdata & ~old_mask;
          state_d       = ST_SET;
        end
      end
      ST_SET: begin
        if (out_free) begin
          map_req.en       = 1'b1;
          map_req.we       = 1'b1;
          map_req.addr     = key_q[KEY_W-1:BIT_W];
          map_req.wdata    = row_q | key_mask;
          ring_req.we      = 1'b1;
          ring_req.wr_addr = head_q;
          ring_req.wdata   = key_q;
          head_d           = head_next;
          miss_d           = miss_inc;
          out_valid_d      = 1'b1;
          out_data_d       = {{(OUT_DATA_W - MISS_W - KEY_W - 2){1'b0}}, miss_inc,
                              old_q, 1'b1, 1'b0};
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_row_q   <= '0;
      cap_q       <= CAP_W'(MAX_SLOTS);
      head_q      <= '0;
      occ_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      occ_q       <= occ_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    old_q      <= old_d;
    row_q      <= row_d;
    out_data_q <= out_data_d;
  end

endmodule
`default_nettype wire

// ===== design/fifc_bitmap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Presence bitmap memory
// Single-port synchronous memory of bitmap rows with registered read data.
// ----------------------------------------------------------------------------
module fifc_bitmap_ram (
  input  wire                           clk_i,
  input  wire fifc_pkg::fifc_map_req_t  req_i,
  output logic [fifc_pkg::ROW_BITS-1:0] rdata_o
);
  import fifc_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/fifc_ring_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot ring memory
// Key storage of the replacement ring, one write and one registered read port.
// ----------------------------------------------------------------------------
module fifc_ring_ram (
  input  wire                          clk_i,
  input  wire fifc_pkg::fifc_ring_req_t req_i,
  output logic [fifc_pkg::KEY_W-1:0]   rdata_o
);
  import fifc_pkg::*;

  logic [KEY_W-1:0] mem [MAX_SLOTS];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/fifc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FIFO replacement cache checker
// Port-level properties of the cache unit, bound to the top level.
// ----------------------------------------------------------------------------
module fifc_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [fifc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result item changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while an item is still in work.");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("A hit reports an eviction.");

  a_evict_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> (m_axis_tdata[11:2] == 10'd0))
    else $error("Evicted key is nonzero without an eviction.");

  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[43:12] != 32'd0))
    else $error("A miss reports a zero miss total.");

endmodule

bind fifo_replacement_cache_unit fifc_checker u_fifc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/fifo_replacement_cache_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO replacement cache unit testbench
// Streams keys into the cache unit and checks each lookup result against a
// local model of the presence bitmap, the eviction ring and the miss counter.
// Capacity is set before the first key and rewritten between phases, where the
// unit must ignore it. Both stream sides idle at random in changing mixes, then never.
// ----------------------------------------------------------------------------
module fifo_replacement_cache_unit_test;
  import fifc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 410;

  typedef struct packed {
    logic [MISS_W-1:0] miss_total;
    logic [KEY_W-1:0]  evicted_key;
    logic              evicted_valid;
    logic              hit;
  } lookup_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tready = 1'b0;
  wire cfg_ready_o;
  wire s_axis_tready;
  wire m_axis_tvalid;
  wire [OUT_DATA_W-1:0] m_axis_tdata;

  int send_idle_pct = 25;
  int recv_idle_pct = 52;

  logic [KEY_W-1:0] pending_keys[$];
  lookup_result_t expected_lookups[$];

  // Local model of the cache state.
  bit key_present[KEY_SPACE];
  logic [KEY_W-1:0] slot_keys[MAX_SLOTS];
  int unsigned ring_head = 0;
  int unsigned occupied = 0;
  logic [MISS_W-1:0] miss_count = '0;
  int unsigned capacity = MAX_SLOTS;

  int error_count = 0;
  int checked_count = 0;
  int hit_count = 0;
  int evict_count = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  fifo_replacement_cache_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void predict_lookup(input logic [KEY_W-1:0] key);
    lookup_result_t r;
    int unsigned slot;
    r = '0;
    if (key_present[key]) begin
      r.hit = 1'b1;
      hit_count++;
    end else begin
      if (miss_count != '1) miss_count++;
      if (occupied >= capacity) begin
        slot = ring_head % capacity;
        r.evicted_valid = 1'b1;
        r.evicted_key = slot_keys[slot];
        key_present[slot_keys[slot]] = 1'b0;
        ring_head = (slot + 1 >= capacity) ? 0 : slot + 1;
        occupied--;
        evict_count++;
      end
      slot = (ring_head + occupied) % capacity;
      slot_keys[slot] = key;
      key_present[key] = 1'b1;
      occupied++;
    end
    r.miss_total = miss_count;
    expected_lookups.push_back(r);
  endfunction

  task automatic note_error(input string what, input lookup_result_t exp_r,
                            input lookup_result_t got_r);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: exp h=%0d ev=%0d key=%0d miss=%0d, got h=%0d ev=%0d key=%0d miss=%0d",
               $realtime, what, exp_r.hit, exp_r.evicted_valid, exp_r.evicted_key,
               exp_r.miss_total, got_r.hit, got_r.evicted_valid, got_r.evicted_key,
               got_r.miss_total);
    end
  endtask

  // Key driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_axis_tready) predict_lookup(s_tdata[KEY_W-1:0]);
      if (!s_tvalid || s_axis_tready) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= IN_DATA_W'(pending_keys.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and stall counter.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t got_r;
    lookup_result_t exp_r;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_tready) begin
        got_r = m_axis_tdata[$bits(lookup_result_t)-1:0];
        checked_count++;
        if (expected_lookups.size() == 0) begin
          note_error("Unexpected result", '0, got_r);
        end else begin
          exp_r = expected_lookups.pop_front();
          if (got_r !== exp_r) note_error("Result mismatch", exp_r, got_r);
        end
      end
      if ((m_axis_tvalid && m_tready) || (s_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (miss_count == 0) begin
      if (value == 0) capacity = 1;
      else if (value > MAX_SLOTS) capacity = MAX_SLOTS;
      else capacity = value;
    end
  endtask

  task automatic queue_random_keys(input int count);
    logic [KEY_W-1:0] pool[256];
    int pool_size;
    int seq_idx;
    int pick;
    pool_size = capacity + capacity / 4 + 2;
    seq_idx = 0;
    for (int i = 0; i < pool_size; i++) pool[i] = KEY_W'($urandom);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        pending_keys.push_back(pool[$urandom_range(pool_size - 1)]);
      end else if (pick < 85) begin
        pending_keys.push_back(pool[seq_idx % pool_size]);
        seq_idx++;
      end else begin
        pending_keys.push_back(KEY_W'($urandom));
      end
    end
  endtask

  task automatic drain_lookups();
    while (pending_keys.size() != 0 || s_tvalid || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout after %0d cycles without progress.", STALL_LIMIT);
    $display("FAIL fifo_replacement_cache_unit");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] final_cap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero and oversized writes are clamped; the last write before any key wins.
    write_capacity(8'd0);
    write_capacity(8'd255);
    write_capacity(8'd200);
    write_capacity(8'd128);
    case ($urandom_range(3))
      0: final_cap = 8'd0;
      1: final_cap = 8'd255;
      2: final_cap = CAP_W'($urandom_range(16, 2));
      default: final_cap = CAP_W'($urandom_range(128, 1));
    endcase
    write_capacity(final_cap);

    pending_keys = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'h155, 10'h2AA, 10'h155,
                     10'h2AA, 10'd512, 10'd513, 10'd514, 10'd512, 10'd513, 10'd514,
                     10'd15, 10'd16, 10'd31, 10'd0, 10'd1023, 10'd1};
    queue_random_keys(RANDOM_PER_PHASE);
    drain_lookups();

    // Capacity writes once keys have been seen must have no effect.
    send_idle_pct <= 52;
    recv_idle_pct <= 25;
    write_capacity(8'd1);
    queue_random_keys(RANDOM_PER_PHASE);
    drain_lookups();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_capacity(8'd255);
    write_capacity(CAP_W'($urandom));
    queue_random_keys(RANDOM_PER_PHASE);
    drain_lookups();

    $display("Checked %0d lookups at capacity %0d: %0d hits, %0d misses, %0d evictions.",
             checked_count, capacity, hit_count, miss_count, evict_count);
    $display("Made %0d capacity writes, those after the first key expected to be ignored.",
             cfg_writes);
    if (error_count == 0) begin
      $display("PASS fifo_replacement_cache_unit");
    end else begin
      $display("%0d errors.", error_count);
      $display("FAIL fifo_replacement_cache_unit");
    end
    $finish;
  end

endmodule
